// File: sv/position_limited_stroke_sequencer_defines.svh
// Assertion macros used by the sequencer core RTL.
`ifndef POSITION_LIMITED_STROKE_SEQUENCER_DEFINES_SVH
`define POSITION_LIMITED_STROKE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define PLSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define PLSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLSS_ASSERT(lbl, prop, msg)
`define PLSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/plss_pkg.sv
package plss_pkg;

  localparam int POT_BITS = 12;
  localparam int CFG_W    = 12;
  localparam int DRV_W    = 16;
  localparam int FUNC_W   = 3;
  localparam int CFG_IDX_W = 2;
  // Signed width that holds a pot difference and any register value.
  localparam int REL_W = ((POT_BITS > CFG_W) ? POT_BITS : CFG_W) + 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHOOT   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SOFT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MANUAL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CAPTURE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ZONE = 2'd2;

  localparam logic [CFG_W-1:0] TRAVEL_RESET    = 12'd320;
  localparam logic [CFG_W-1:0] EMERGENCY_RESET = 12'd600;
  localparam logic [CFG_W-1:0] SLOW_ZONE_RESET = 12'd35;

  // Drive levels in Q1.14.
  localparam logic signed [DRV_W-1:0] DRV_FULL      = 16'sd16384;
  localparam logic signed [DRV_W-1:0] DRV_NEG_FULL  = -16'sd16384;
  localparam logic signed [DRV_W-1:0] DRV_SOFT      = 16'sd5734;
  localparam logic signed [DRV_W-1:0] DRV_FAST_BACK = -16'sd13107;
  localparam logic signed [DRV_W-1:0] DRV_SLOW_BACK = -16'sd3277;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POT_BITS-1:0]     pot_sample;
    logic signed [DRV_W-1:0] manual_drive;
  } plss_in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] motor_drive;
    logic                    idle;
  } plss_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] travel_distance;
    logic [CFG_W-1:0] emergency_threshold;
    logic [CFG_W-1:0] slow_zone;
  } plss_cfg_t;

endpackage

// File: sv/plss_cfg_regs.sv
module plss_cfg_regs
  import plss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output plss_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_distance     <= TRAVEL_RESET;
      cfg.emergency_threshold <= EMERGENCY_RESET;
      cfg.slow_zone           <= SLOW_ZONE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRAVEL:    cfg.travel_distance     <= cfg_data;
        REG_EMERGENCY: cfg.emergency_threshold <= cfg_data;
        REG_SLOW_ZONE: cfg.slow_zone           <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/plss_input_stage.sv
module plss_input_stage
  import plss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  plss_in_t in_data,
  input  logic     take,
  output logic     item_valid,
  output plss_in_t item
);

  logic accept;

  // The held request may leave in the same cycle that a new one arrives.
  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (take) begin
        item_valid <= 1'b0;
      end
      if (accept) begin
        item_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

endmodule

// File: sv/plss_core.sv
`include "position_limited_stroke_sequencer_defines.svh"

module plss_core
  import plss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  plss_in_t  item,
  input  plss_cfg_t cfg,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output plss_out_t out_data
);

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_SHOOT  = 3'd1,
    MODE_RETURN = 3'd2,
    MODE_MANUAL = 3'd3,
    MODE_SOFT   = 3'd5,
    MODE_EMERG  = 3'd6
  } mode_t;

  mode_t                   mode, mode_next, tick_mode;
  logic [POT_BITS-1:0]     start_position, start_position_next;
  logic                    capture_pending, capture_pending_next;
  logic signed [DRV_W-1:0] drive_level, drive_level_next, tick_drive;
  logic signed [DRV_W-1:0] manual_sat;
  logic signed [REL_W-1:0] rel, travel_s, slow_s;
  logic                    emit;

  // A request moves on whenever the result register is free or being emptied.
  assign take = item_valid && (!out_valid || !out_stall);

  always_comb begin
    if (item.manual_drive > DRV_FULL) begin
      manual_sat = DRV_FULL;
    end else if (item.manual_drive < DRV_NEG_FULL) begin
      manual_sat = DRV_NEG_FULL;
    end else begin
      manual_sat = item.manual_drive;
    end
  end

  // Position is taken against the start held before any capture on this tick.
  assign rel      = $signed(REL_W'(item.pot_sample)) - $signed(REL_W'(start_position));
  assign travel_s = $signed(REL_W'(cfg.travel_distance));
  assign slow_s   = $signed(REL_W'(cfg.slow_zone));

  always_comb begin
    tick_mode  = mode;
    tick_drive = drive_level;
    if (tick_mode == MODE_SHOOT || tick_mode == MODE_SOFT) begin
      if (rel < travel_s) begin
        tick_drive = (tick_mode == MODE_SOFT) ? DRV_SOFT : DRV_FULL;
      end
      if (rel > travel_s) begin
        tick_mode = MODE_RETURN;
      end
    end
    // A stroke that has just ended starts its return on the same tick.
    if (tick_mode == MODE_RETURN || tick_mode == MODE_EMERG) begin
      if (rel > slow_s) begin
        tick_drive = DRV_FAST_BACK;
      end else if (rel > 0) begin
        tick_drive = DRV_SLOW_BACK;
      end else begin
        tick_mode = MODE_STOP;
      end
    end
    // Manual drive is shown once, then the sequencer drops back to stop.
    if (tick_mode == MODE_STOP) begin
      tick_drive = '0;
    end else if (tick_mode == MODE_MANUAL) begin
      tick_mode = MODE_STOP;
    end
  end

  always_comb begin
    mode_next            = mode;
    drive_level_next     = drive_level;
    start_position_next  = start_position;
    capture_pending_next = capture_pending;
    emit                 = 1'b0;
    if (take) begin
      unique case (item.func)
        FUNC_TICK: begin
          emit             = 1'b1;
          mode_next        = tick_mode;
          drive_level_next = tick_drive;
          if (capture_pending) begin
            start_position_next  = item.pot_sample;
            capture_pending_next = 1'b0;
          end
        end
        FUNC_SHOOT: begin
          if (mode == MODE_STOP) mode_next = MODE_SHOOT;
        end
        FUNC_SOFT: begin
          if (mode == MODE_STOP) mode_next = MODE_SOFT;
        end
        FUNC_MANUAL: begin
          if (mode != MODE_EMERG) begin
            mode_next        = MODE_MANUAL;
            drive_level_next = manual_sat;
          end
        end
        FUNC_CAPTURE: begin
          capture_pending_next = 1'b1;
        end
        FUNC_CHECK: begin
          if (REL_W'(item.pot_sample) > REL_W'(cfg.emergency_threshold)) begin
            mode_next = MODE_EMERG;
          end
        end
        FUNC_STOP: begin
          mode_next = MODE_STOP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_STOP;
      start_position  <= '0;
      capture_pending <= 1'b1;
      drive_level     <= '0;
      out_valid       <= 1'b0;
    end else begin
      mode            <= mode_next;
      start_position  <= start_position_next;
      capture_pending <= capture_pending_next;
      drive_level     <= drive_level_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.motor_drive <= drive_level_next;
      out_data.idle        <= (mode_next == MODE_STOP);
    end
  end

  `PLSS_ASSERT(a_capture_clears, (take && item.func == FUNC_TICK) |=> !capture_pending,
    "capture request still pending after a tick")
  `PLSS_ASSERT(a_result_from_tick, $rose(out_valid) |-> $past(emit),
    "result appeared without a tick")
  `PLSS_ASSERT(a_idle_matches_mode, emit |=> (out_data.idle == (mode == MODE_STOP)),
    "idle flag disagrees with the mode left by the tick")
  `PLSS_ASSERT(a_drive_range,
    out_valid |-> (out_data.motor_drive <= DRV_FULL && out_data.motor_drive >= DRV_NEG_FULL),
    "motor drive outside full scale")

endmodule

// File: sv/position_limited_stroke_sequencer.sv
// A request accepted into the input register moves on when the core takes it; a tick's result
// is registered in the result register. Throughput: one request per cycle while not stalled;
// the mode compare and update is a single registered pass.
// Only ticks give results; a held result stalls new requests only once the input register is full.
// Reset (synchronous, active high): mode stop, drive zero, start position zero, a capture
// pending for the first tick, registers at 320, 600 and 35.
module position_limited_stroke_sequencer
  import plss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plss_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plss_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  plss_cfg_t cfg;
  plss_in_t  item;
  logic      item_valid;
  logic      take;

  plss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plss_input_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  plss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: tb/stroke_drive_checker.sv
`timescale 1ns / 1ps
module stroke_drive_checker
  import plss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  plss_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  plss_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_SHOOT  = 3'd1,
    MODE_RETURN = 3'd2,
    MODE_MANUAL = 3'd3,
    MODE_SOFT   = 3'd5,
    MODE_EMERG  = 3'd6
  } seq_mode_t;

  seq_mode_t               mode;
  logic [POT_BITS-1:0]     start_pos;
  bit                      capture_due;
  logic signed [DRV_W-1:0] drive_lvl;
  plss_cfg_t               cfg;
  plss_out_t               expected_drives[$];
  int                      fails;

  task automatic advance_stroke(input int rel, input logic signed [DRV_W-1:0] fwd);
    if (rel < int'(cfg.travel_distance)) drive_lvl = fwd;
    if (rel > int'(cfg.travel_distance)) mode = MODE_RETURN;
  endtask

  task automatic advance_return(input int rel);
    if (rel > int'(cfg.slow_zone)) drive_lvl = DRV_FAST_BACK;
    if (rel > 0 && rel <= int'(cfg.slow_zone)) drive_lvl = DRV_SLOW_BACK;
    if (rel <= 0) mode = MODE_STOP;
  endtask

  // Applies one request to the tracked state; only a tick yields a drive result.
  task automatic predict_drive(input plss_in_t req, output bit has_res, output plss_out_t res);
    int manual;
    int rel;
    manual = int'(req.manual_drive);
    if (manual > int'(DRV_FULL)) manual = int'(DRV_FULL);
    if (manual < int'(DRV_NEG_FULL)) manual = int'(DRV_NEG_FULL);
    has_res = 1'b0;
    res = '0;
    case (req.func)
      FUNC_SHOOT: if (mode == MODE_STOP) mode = MODE_SHOOT;
      FUNC_SOFT: if (mode == MODE_STOP) mode = MODE_SOFT;
      FUNC_MANUAL: begin
        if (mode != MODE_EMERG) begin
          mode = MODE_MANUAL;
          drive_lvl = DRV_W'(manual);
        end
      end
      FUNC_CAPTURE: capture_due = 1'b1;
      FUNC_CHECK: if (req.pot_sample > cfg.emergency_threshold) mode = MODE_EMERG;
      FUNC_STOP: mode = MODE_STOP;
      FUNC_TICK: begin
        // The position is taken against the start held before this tick's capture.
        rel = int'(req.pot_sample) - int'(start_pos);
        if (capture_due) begin
          start_pos = req.pot_sample;
          capture_due = 1'b0;
        end
        if (mode == MODE_SOFT) advance_stroke(rel, DRV_SOFT);
        if (mode == MODE_SHOOT) advance_stroke(rel, DRV_FULL);
        if (mode == MODE_EMERG) advance_return(rel);
        if (mode == MODE_RETURN) advance_return(rel);
        if (mode == MODE_STOP) drive_lvl = '0;
        if (mode == MODE_MANUAL) mode = MODE_STOP;
        has_res = 1'b1;
        res.motor_drive = drive_lvl;
        res.idle = (mode == MODE_STOP);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    plss_out_t want;
    plss_out_t got;
    bit has_res;
    if (rst) begin
      mode = MODE_STOP;
      start_pos = '0;
      capture_due = 1'b1;
      drive_lvl = '0;
      cfg.travel_distance = TRAVEL_RESET;
      cfg.emergency_threshold = EMERGENCY_RESET;
      cfg.slow_zone = SLOW_ZONE_RESET;
      expected_drives.delete();
      fails = 0;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      // Results are retired before the new request is predicted, so a request
      // accepted at this edge can never be matched against a result at the same edge.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_drives.size() == 0) begin
          if (fails < 10)
            $display("%0t: result with none pending: motor_drive %0d idle %0b",
                     $realtime, got.motor_drive, got.idle);
          fails++;
        end else begin
          want = expected_drives.pop_front();
          if (got.motor_drive !== want.motor_drive || got.idle !== want.idle) begin
            if (fails < 10)
              $display("%0t: mismatch: motor_drive exp %0d got %0d, idle exp %0b got %0b",
                       $realtime, want.motor_drive, got.motor_drive, want.idle, got.idle);
            fails++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TRAVEL:    cfg.travel_distance = cfg_data;
          REG_EMERGENCY: cfg.emergency_threshold = cfg_data;
          REG_SLOW_ZONE: cfg.slow_zone = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_drive(in_data, has_res, want);
        if (has_res) expected_drives.push_back(want);
      end
      fail_count <= fails;
      pending_count <= expected_drives.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import plss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1650;
  localparam int PHASE_ITEMS = 300;
  localparam int TAIL_ITEMS  = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  plss_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  plss_out_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TRAVEL;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int items_sent = 0;
  int cur_start = 0;
  bit capture_armed = 1'b1;
  bit quiet_tail = 1'b0;
  bit hold_off_req = 1'b0;
  bit gappy = 1'b1;
  logic [CFG_W-1:0] travel_cfg = TRAVEL_RESET;
  logic [CFG_W-1:0] emerg_cfg = EMERGENCY_RESET;
  logic [CFG_W-1:0] slow_cfg = SLOW_ZONE_RESET;

  position_limited_stroke_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stroke_drive_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(input logic [FUNC_W-1:0] f, input int pot, input logic [DRV_W-1:0] man);
    plss_in_t req;
    int p;
    if (!quiet_tail && gappy && $urandom_range(0, 5) == 0)
      pause_sender($urandom_range(1, 17));
    p = (pot < 0) ? 0 : (pot > 4095) ? 4095 : pot;
    req.func = f;
    req.pot_sample = p[POT_BITS-1:0];
    req.manual_drive = man;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    if (f == FUNC_CAPTURE) capture_armed = 1'b1;
    if (f == FUNC_TICK && capture_armed) begin
      cur_start = p;
      capture_armed = 1'b0;
    end
    if (f != FUNC_UNUSED) items_sent++;
  endtask

  // Lets every pending result come out and gives a trailing command time to finish.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] e,
                            input logic [CFG_W-1:0] s);
    wait_results_done();
    write_reg(REG_TRAVEL, t);
    write_reg(REG_EMERGENCY, e);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    write_reg(REG_SLOW_ZONE, s);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    travel_cfg = t;
    emerg_cfg = e;
    slow_cfg = s;
  endtask

  task automatic random_request();
    case ($urandom_range(0, 7))
      0: send(FUNC_MANUAL, $urandom, DRV_W'($urandom));
      1: send(FUNC_CHECK, int'(emerg_cfg) + int'($urandom_range(0, 2)) - 1, DRV_W'($urandom));
      2: send(FUNC_CHECK, $urandom_range(0, 4095), DRV_W'($urandom));
      3: send(FUNC_STOP, $urandom, DRV_W'($urandom));
      4: send(FUNC_UNUSED, $urandom, DRV_W'($urandom));
      5: send(($urandom_range(0, 1) == 0) ? FUNC_SOFT : FUNC_SHOOT, $urandom, DRV_W'($urandom));
      6: send(FUNC_CAPTURE, $urandom, DRV_W'($urandom));
      default: send(FUNC_TICK, $urandom_range(0, 4095), DRV_W'($urandom));
    endcase
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) random_request();
  endtask

  // One armed stroke: ticks climb past the travel distance, then fall back through
  // the slow zone to the start.
  task automatic stroke_run();
    int rel;
    int step;
    int n;
    if ($urandom_range(0, 3) == 0) begin
      send(FUNC_CAPTURE, $urandom, DRV_W'($urandom));
      send(FUNC_TICK, $urandom_range(0, 3000), DRV_W'($urandom));
    end
    send(($urandom_range(0, 2) == 0) ? FUNC_SOFT : FUNC_SHOOT, $urandom, DRV_W'($urandom));
    step = int'(travel_cfg) / int'($urandom_range(6, 20)) + 1;
    rel = 0;
    n = 0;
    while (rel <= int'(travel_cfg) && n < 40) begin
      send(FUNC_TICK, cur_start + rel, DRV_W'($urandom));
      maybe_noise();
      // Land on the travel distance exactly before passing it.
      if (rel < int'(travel_cfg) && rel + step > int'(travel_cfg)) rel = int'(travel_cfg);
      else rel += step;
      n++;
    end
    rel += int'($urandom_range(0, 3));
    send(FUNC_TICK, cur_start + rel, DRV_W'($urandom));
    step = rel / int'($urandom_range(4, 12)) + 1;
    n = 0;
    while (rel > 0 && n < 40) begin
      if (rel > int'(slow_cfg) && rel - step < int'(slow_cfg)) rel = int'(slow_cfg);
      else if (rel <= int'(slow_cfg)) rel -= int'(slow_cfg) / 3 + 1;
      else rel -= step;
      if (rel <= 0) rel = 0 - int'($urandom_range(0, 2));
      send(FUNC_TICK, cur_start + rel, DRV_W'($urandom));
      maybe_noise();
      n++;
    end
    if ($urandom_range(0, 3) == 0) send(FUNC_STOP, $urandom, DRV_W'($urandom));
  endtask

  task automatic directed_run();
    send(FUNC_TICK, 100, 16'h0000);
    send(FUNC_UNUSED, 4095, 16'hffff);
    send(FUNC_MANUAL, 0, 16'h7fff);
    send(FUNC_TICK, 100, 16'h0000);
    send(FUNC_MANUAL, 0, 16'h8000);
    send(FUNC_TICK, 100, 16'h0000);
    send(FUNC_MANUAL, 0, DRV_FULL);
    send(FUNC_TICK, 100, 16'h0000);
    send(FUNC_MANUAL, 0, DRV_NEG_FULL);
    send(FUNC_TICK, 100, 16'h0000);
    // Full stroke with the second arm refused while busy.
    send(FUNC_SHOOT, 0, 16'h0000);
    send(FUNC_SOFT, 0, 16'h0000);
    send(FUNC_TICK, 100, 16'h0000);
    send(FUNC_TICK, 420, 16'h0000);
    send(FUNC_TICK, 421, 16'h0000);
    send(FUNC_TICK, 135, 16'h0000);
    send(FUNC_TICK, 100, 16'h0000);
    // Soft stroke overshooting into its return, then an emergency return, with manual refused.
    send(FUNC_SOFT, 0, 16'h0000);
    send(FUNC_TICK, 4095, 16'h0000);
    send(FUNC_CHECK, 601, 16'h0000);
    send(FUNC_MANUAL, 0, 16'h1234);
    send(FUNC_TICK, 200, 16'h0000);
    send(FUNC_CHECK, 600, 16'h0000);
    send(FUNC_TICK, 0, 16'h0000);
    send(FUNC_SHOOT, 0, 16'h0000);
    send(FUNC_TICK, 150, 16'h0000);
    send(FUNC_STOP, 0, 16'h0000);
    send(FUNC_TICK, 150, 16'h0000);
    send(FUNC_CAPTURE, 0, 16'h0000);
    send(FUNC_TICK, 0, 16'h0000);
  endtask

  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(1, 17);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_run();
    for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase)
        0: set_config('0, '0, '0);
        1: set_config('1, '1, '1);
        2: set_config(TRAVEL_RESET, EMERGENCY_RESET, SLOW_ZONE_RESET);
        default: begin
          if ($urandom_range(0, 3) == 0)
            set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
          else
            set_config(CFG_W'($urandom_range(0, 700)), CFG_W'($urandom_range(0, 4095)),
                       CFG_W'($urandom_range(0, 100)));
        end
      endcase
      if (phase == 2) begin
        // The receiver holds off while requests keep coming, so the block backs up.
        gappy = 1'b0;
        hold_off_req = 1'b1;
        repeat (30) send(FUNC_TICK, $urandom_range(0, 4095), DRV_W'($urandom));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        if (items_sent >= ITEM_TARGET - TAIL_ITEMS) quiet_tail = 1'b1;
        gappy = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 6) == 0) repeat (10) random_request();
        else stroke_run();
      end
    end
    wait_results_done();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
